// ----- rtl/lgne_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgne_pkg: shared types and constants
// Payload structs, action and function codes for the gene network evaluator.
// ----------------------------------------------------------------------------
package lgne_pkg;

	localparam int GENE_COUNT_DEF = 256;
	localparam int WORD_BITS_DEF  = 64;

	localparam logic [2:0] ACT_LOAD     = 3'd0;
	localparam logic [2:0] ACT_OVERRIDE = 3'd1;
	localparam logic [2:0] ACT_EVAL     = 3'd2;
	localparam logic [2:0] ACT_MUTATE   = 3'd3;
	localparam logic [2:0] ACT_READ     = 3'd4;

	localparam logic [2:0] FN_NOP  = 3'd0;
	localparam logic [2:0] FN_NOT  = 3'd1;
	localparam logic [2:0] FN_AND  = 3'd2;
	localparam logic [2:0] FN_NAND = 3'd3;
	localparam logic [2:0] FN_OR   = 3'd4;
	localparam logic [2:0] FN_NOR  = 3'd5;
	localparam logic [2:0] FN_XOR  = 3'd6;
	localparam logic [2:0] FN_XNOR = 3'd7;

	localparam logic [1:0] MUT_SRC_A = 2'd0;
	localparam logic [1:0] MUT_SRC_B = 2'd1;
	localparam logic [1:0] MUT_FUNC  = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  gene_index;
		logic [2:0]  function_code;
		logic [7:0]  source_a;
		logic [7:0]  source_b;
		logic [63:0] word_value;
		logic [1:0]  mutate_field;
	} lgne_in_t;

	typedef struct packed {
		logic [63:0] result_word;
		logic [2:0]  out_function;
		logic [7:0]  out_source_a;
		logic [7:0]  out_source_b;
		logic        was_active;
		logic        error;
	} lgne_out_t;

endpackage

// ----- rtl/logic_gene_network_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logic_gene_network_evaluator
// Gene table with memoized depth-first evaluation over one shared logic unit.
// ----------------------------------------------------------------------------
//  channel  | signals            | handshake
//  ---------+--------------------+----------------------------------
//  command  | start, busy, cmd   | transfer when start && !busy
//  result   | done, rsp          | one-cycle strobe, cannot stall
//
// Load, override, mutate, read and unused actions keep busy high through the
// record read, update, re-read and result states; done follows in the next
// cycle. Evaluate of a valid gene: record read, then result. Otherwise each
// walk step runs stack read, record, source a, source b and compute, and a
// success ends with re-read and result; a gene with two pending sources takes
// up to three steps. Reset clears the valid, written and on-walk marks at
// once; entries never written read as a NOP gene with zero sources and word.
// ----------------------------------------------------------------------------
module logic_gene_network_evaluator #(
	parameter int WORD_BITS  = lgne_pkg::WORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lgne_pkg::lgne_in_t  cmd,
	output logic                done,
	output lgne_pkg::lgne_out_t rsp
);
	import lgne_pkg::*;

	localparam int GENE_COUNT = GENE_COUNT_DEF;
	localparam int GW = (GENE_COUNT > 1) ? $clog2(GENE_COUNT) : 1;
	localparam int SW = $clog2(GENE_COUNT + 1);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_RD    = 11'b00000000010,
		ST_UPD   = 11'b00000000100,
		ST_TOP   = 11'b00000001000,
		ST_GENE  = 11'b00000010000,
		ST_SRCA  = 11'b00000100000,
		ST_SRCB  = 11'b00001000000,
		ST_CALC  = 11'b00010000000,
		ST_ROOT  = 11'b00100000000,
		ST_DONE  = 11'b01000000000,
		ST_SYNC  = 11'b10000000000
	} state_t;

	state_t state_q;

	// gene record memory: function, sources, word (read data registered)
	logic [2:0]           fn_mem [GENE_COUNT];
	logic [7:0]           sa_mem [GENE_COUNT];
	logic [7:0]           sb_mem [GENE_COUNT];
	logic [WORD_BITS-1:0] wd_mem [GENE_COUNT];
	logic [GW-1:0]        stk_mem [GENE_COUNT];
	logic [GENE_COUNT-1:0] valid_q, written_q, onwalk_q;

	lgne_in_t             cmd_q;
	logic [GW-1:0]        g_q, cur_q, ra_q, rb_q;
	logic [SW-1:0]        sp_q;
	logic                 err_q;

	logic [GW-1:0]        rd_addr;
	logic [2:0]           rd_fn_q;
	logic [7:0]           rd_sa_q, rd_sb_q;
	logic [WORD_BITS-1:0] rd_wd_q, wa_q, wb_q;
	logic [GW-1:0]        stk_rd_q;
	logic                 rd_wr_q;

	logic                 we;
	logic [GW-1:0]        wa;
	logic [2:0]           w_fn;
	logic [7:0]           w_sa, w_sb;
	logic [WORD_BITS-1:0] w_wd;
	logic                 stk_we;
	logic [GW-1:0]        stk_wa, stk_wd;

	function automatic logic [GW-1:0] gmod(input logic [7:0] v);
		logic [31:0] t;
		t = 32'(v) % GENE_COUNT;
		return t[GW-1:0];
	endfunction

	logic [2:0]           g_fn;
	logic [7:0]           g_sa, g_sb;
	logic [WORD_BITS-1:0] g_wd;
	assign g_fn = rd_wr_q ? rd_fn_q : FN_NOP;
	assign g_sa = rd_wr_q ? rd_sa_q : 8'd0;
	assign g_sb = rd_wr_q ? rd_sb_q : 8'd0;
	assign g_wd = rd_wr_q ? rd_wd_q : '0;

	logic binary;
	assign binary = (g_fn > FN_NOT);

	logic [WORD_BITS-1:0] fn_res;
	always_comb begin
		case (g_fn)
			FN_NOP:  fn_res = wa_q;
			FN_NOT:  fn_res = ~wa_q;
			FN_AND:  fn_res = wa_q & wb_q;
			FN_NAND: fn_res = ~(wa_q & wb_q);
			FN_OR:   fn_res = wa_q | wb_q;
			FN_NOR:  fn_res = ~(wa_q | wb_q);
			FN_XOR:  fn_res = wa_q ^ wb_q;
			default: fn_res = ~(wa_q ^ wb_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			fn_mem[wa] <= w_fn;
			sa_mem[wa] <= w_sa;
			sb_mem[wa] <= w_sb;
			wd_mem[wa] <= w_wd;
		end
		rd_fn_q <= fn_mem[rd_addr];
		rd_sa_q <= sa_mem[rd_addr];
		rd_sb_q <= sb_mem[rd_addr];
		rd_wd_q <= wd_mem[rd_addr];
		if (stk_we)
			stk_mem[stk_wa] <= stk_wd;
		stk_rd_q <= stk_mem[sp_q[GW-1:0] - GW'(1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_wr_q <= 1'b0;
		else
			rd_wr_q <= written_q[rd_addr];
	end

	// read address and write controls
	always_comb begin
		rd_addr = g_q;
		we      = 1'b0;
		wa      = g_q;
		w_fn    = g_fn;
		w_sa    = g_sa;
		w_sb    = g_sb;
		w_wd    = g_wd;
		case (state_q)
			ST_IDLE: rd_addr = gmod(cmd.gene_index);
			ST_TOP:  rd_addr = stk_rd_q;
			ST_GENE: rd_addr = gmod(g_sa);
			ST_SRCA: rd_addr = rb_q;
			ST_SRCB: rd_addr = cur_q;
			ST_CALC: begin
				rd_addr = g_q;
				if (valid_q[ra_q] && (!binary || valid_q[rb_q])) begin
					we   = 1'b1;
					wa   = cur_q;
					w_wd = fn_res;
				end
			end
			ST_UPD: begin
				we = (cmd_q.action == ACT_LOAD) || (cmd_q.action == ACT_OVERRIDE)
					|| (cmd_q.action == ACT_MUTATE);
				case (cmd_q.action)
					ACT_LOAD: begin
						w_fn = cmd_q.function_code;
						w_sa = cmd_q.source_a;
						w_sb = cmd_q.source_b;
						w_wd = '0;
					end
					ACT_OVERRIDE: w_wd = cmd_q.word_value[WORD_BITS-1:0];
					ACT_MUTATE: begin
						if (cmd_q.mutate_field == MUT_SRC_A) w_sa = cmd_q.source_a;
						if (cmd_q.mutate_field == MUT_SRC_B) w_sb = cmd_q.source_b;
						if (cmd_q.mutate_field == MUT_FUNC)  w_fn = cmd_q.function_code;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			written_q <= '0;
			onwalk_q  <= '0;
			sp_q      <= '0;
			err_q     <= 1'b0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			if (we) written_q[wa] <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RD;
						err_q   <= 1'b0;
					end
				end
				ST_RD: begin
					if (cmd_q.action == ACT_EVAL) begin
						if (!valid_q[g_q]) begin
							onwalk_q[g_q] <= 1'b1;
							sp_q          <= SW'(1);
							state_q       <= ST_ROOT;
						end else
							state_q <= ST_DONE;
					end else
						state_q <= ST_UPD;
				end
				ST_ROOT: state_q <= ST_TOP;
				ST_UPD: begin
					if (cmd_q.action == ACT_LOAD || cmd_q.action == ACT_MUTATE)
						valid_q[g_q] <= 1'b0;
					else if (cmd_q.action == ACT_OVERRIDE)
						valid_q[g_q] <= 1'b1;
					state_q <= ST_SYNC;
				end
				// re-read the record after its write before building the result
				ST_SYNC: state_q <= ST_DONE;
				ST_TOP: begin
					cur_q   <= stk_rd_q;
					state_q <= ST_GENE;
				end
				ST_GENE: begin
					ra_q    <= gmod(g_sa);
					rb_q    <= gmod(g_sb);
					state_q <= ST_SRCA;
				end
				ST_SRCA: begin
					wa_q    <= g_wd;
					state_q <= ST_SRCB;
				end
				ST_SRCB: begin
					wb_q    <= g_wd;
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (!valid_q[ra_q] || (binary && !valid_q[rb_q])) begin
						if (onwalk_q[valid_q[ra_q] ? rb_q : ra_q]
							|| sp_q == SW'(GENE_COUNT)) begin
							err_q    <= 1'b1;
							onwalk_q <= '0;
							sp_q     <= '0;
							state_q  <= ST_DONE;
						end else begin
							onwalk_q[valid_q[ra_q] ? rb_q : ra_q] <= 1'b1;
							sp_q    <= sp_q + SW'(1);
							state_q <= ST_ROOT;
						end
					end else begin
						valid_q[cur_q]  <= 1'b1;
						onwalk_q[cur_q] <= 1'b0;
						sp_q            <= sp_q - SW'(1);
						state_q         <= (sp_q == SW'(1)) ? ST_SYNC : ST_ROOT;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stack push: the stack write happens in ST_RD (root) and ST_CALC (need)
	logic [GW-1:0] push_gene;
	logic          push_en;
	always_comb begin
		push_en   = 1'b0;
		push_gene = g_q;
		if (state_q == ST_RD && cmd_q.action == ACT_EVAL && !valid_q[g_q])
			push_en = 1'b1;
		if (state_q == ST_CALC && (!valid_q[ra_q] || (binary && !valid_q[rb_q]))) begin
			push_en   = 1'b1;
			push_gene = valid_q[ra_q] ? rb_q : ra_q;
		end
	end

	assign stk_we = push_en;
	assign stk_wa = sp_q[GW-1:0];
	assign stk_wd = push_gene;

	logic          was_q;
	logic          word_out;
	logic          unused_act;
	assign word_out = (cmd_q.action == ACT_EVAL && !err_q) || cmd_q.action == ACT_OVERRIDE
		|| cmd_q.action == ACT_READ;
	assign unused_act = (cmd_q.action > ACT_READ);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
			g_q   <= gmod(cmd.gene_index);
		end
		if (state_q == ST_UPD)
			was_q <= valid_q[g_q];
		if (state_q == ST_DONE) begin
			rsp.result_word  <= word_out ? 64'(g_wd) : 64'd0;
			rsp.out_function <= unused_act ? 3'd0 : g_fn;
			rsp.out_source_a <= unused_act ? 8'd0 : g_sa;
			rsp.out_source_b <= unused_act ? 8'd0 : g_sb;
			rsp.was_active   <= (cmd_q.action == ACT_MUTATE) ? was_q : 1'b0;
			rsp.error        <= (cmd_q.action == ACT_EVAL) ? err_q : 1'b0;
		end
	end

endmodule

// ----- dv/lgne_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgne_checker
// Watches command and result transfers of the gene network evaluator, keeps
// its own copy of the gene table, predicts each result and compares it.
// ----------------------------------------------------------------------------
module lgne_checker
	import lgne_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  lgne_in_t  cmd,
	input  logic      done,
	input  lgne_out_t rsp,
	output int        fail_count,
	output int        outstanding
);

	logic [2:0]  gene_fn [256];
	logic [7:0]  gene_a  [256];
	logic [7:0]  gene_b  [256];
	logic [63:0] gene_word [256];
	logic        gene_valid [256];

	lgne_out_t   result_q [$];

	function automatic logic [63:0] gate_word(input logic [2:0] f, input logic [63:0] a,
			input logic [63:0] b);
		case (f)
			FN_NOP:  return a;
			FN_NOT:  return ~a;
			FN_AND:  return a & b;
			FN_NAND: return ~(a & b);
			FN_OR:   return a | b;
			FN_NOR:  return ~(a | b);
			FN_XOR:  return a ^ b;
			default: return ~(a ^ b);
		endcase
	endfunction

	// depth-first walk with memoization; returns 0 when a cycle is hit or the stack fills
	function automatic logic walk_gene(input logic [7:0] root, output logic [63:0] w);
		logic [7:0] stk [256];
		logic       on_stk [256];
		int         sp;
		logic       ok;
		logic [7:0] g, a, b, need;
		logic       binary, needed;
		sp = 0;
		ok = 1'b1;
		for (int i = 0; i < 256; i++) on_stk[i] = 1'b0;
		if (!gene_valid[root]) begin
			stk[sp] = root;
			sp++;
			on_stk[root] = 1'b1;
		end
		while (sp > 0 && ok) begin
			g = stk[sp - 1];
			a = gene_a[g];
			b = gene_b[g];
			binary = gene_fn[g] > FN_NOT;
			needed = 1'b0;
			need = '0;
			if (!gene_valid[a]) begin
				needed = 1'b1;
				need = a;
			end else if (binary && !gene_valid[b]) begin
				needed = 1'b1;
				need = b;
			end
			if (needed) begin
				if (on_stk[need] || sp >= 256) begin
					ok = 1'b0;
				end else begin
					stk[sp] = need;
					sp++;
					on_stk[need] = 1'b1;
				end
			end else begin
				gene_word[g] = gate_word(gene_fn[g], gene_word[a],
					binary ? gene_word[b] : 64'd0);
				gene_valid[g] = 1'b1;
				on_stk[g] = 1'b0;
				sp--;
			end
		end
		w = ok ? gene_word[root] : 64'd0;
		return ok;
	endfunction

	function automatic lgne_out_t predict_result(input lgne_in_t c);
		lgne_out_t  r;
		logic [7:0] g;
		logic [63:0] w;
		r = '0;
		g = c.gene_index;
		case (c.action)
			ACT_LOAD: begin
				gene_fn[g] = c.function_code;
				gene_a[g] = c.source_a;
				gene_b[g] = c.source_b;
				gene_word[g] = '0;
				gene_valid[g] = 1'b0;
			end
			ACT_OVERRIDE: begin
				gene_word[g] = c.word_value;
				gene_valid[g] = 1'b1;
				r.result_word = c.word_value;
			end
			ACT_EVAL: begin
				r.error = !walk_gene(g, w);
				r.result_word = w;
			end
			ACT_MUTATE: begin
				if (c.mutate_field == MUT_SRC_A) gene_a[g] = c.source_a;
				else if (c.mutate_field == MUT_SRC_B) gene_b[g] = c.source_b;
				else if (c.mutate_field == MUT_FUNC) gene_fn[g] = c.function_code;
				r.was_active = gene_valid[g];
				gene_valid[g] = 1'b0;
			end
			ACT_READ: r.result_word = gene_word[g];
			default: return '0;
		endcase
		r.out_function = gene_fn[g];
		r.out_source_a = gene_a[g];
		r.out_source_b = gene_b[g];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lgne_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) begin
				gene_fn[i] = FN_NOP;
				gene_a[i] = '0;
				gene_b[i] = '0;
				gene_word[i] = '0;
				gene_valid[i] = 1'b0;
			end
			result_q.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (result_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result with nothing expected: %p", $realtime, rsp);
					fail_count <= fail_count + 1;
				end else begin
					want = result_q.pop_front();
					if (rsp.result_word !== want.result_word
							|| rsp.out_function !== want.out_function
							|| rsp.out_source_a !== want.out_source_a
							|| rsp.out_source_b !== want.out_source_b
							|| rsp.was_active !== want.was_active
							|| rsp.error !== want.error) begin
						if (fail_count < 10)
							$display("%0t: mismatch: expected %p actual %p",
								$realtime, want, rsp);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				result_q.push_back(predict_result(cmd));
			outstanding <= result_q.size();
		end
	end

endmodule

// ----- dv/tb_logic_gene_network_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_logic_gene_network_evaluator
// Directed and random gene commands with random sender gaps; results are
// predicted and compared by lgne_checker.
// ----------------------------------------------------------------------------
module tb_logic_gene_network_evaluator;
	import lgne_pkg::*;

	localparam int CYCLE_LIMIT = 40000000;
	localparam int RANDOM_CMDS = 1825;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	lgne_in_t  cmd;
	logic      done;
	lgne_out_t rsp;
	int        fail_count;
	int        outstanding;
	int        cycles = 0;
	logic      no_gaps;

	logic_gene_network_evaluator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	lgne_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .fail_count(fail_count), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("logic_gene_network_evaluator regression: fail");
			$finish;
		end
	end

	task automatic send_cmd(input lgne_in_t c);
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		// transfer done at this edge; maybe leave a gap before the next one
		if (!no_gaps && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic lgne_in_t make_cmd(input logic [2:0] act, input logic [7:0] g,
			input logic [2:0] f, input logic [7:0] a, input logic [7:0] b,
			input logic [63:0] w, input logic [1:0] m);
		lgne_in_t c;
		c.action = act;
		c.gene_index = g;
		c.function_code = f;
		c.source_a = a;
		c.source_b = b;
		c.word_value = w;
		c.mutate_field = m;
		return c;
	endfunction

	// mostly a small pool so walks go deep and cycles show up
	function automatic logic [7:0] pick_gene();
		if ($urandom_range(0, 99) < 80) return 8'($urandom_range(0, 31));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic lgne_in_t random_cmd();
		lgne_in_t   c;
		int         roll;
		logic [2:0] act;
		roll = $urandom_range(0, 99);
		if (roll < 25) act = ACT_LOAD;
		else if (roll < 40) act = ACT_OVERRIDE;
		else if (roll < 70) act = ACT_EVAL;
		else if (roll < 85) act = ACT_MUTATE;
		else if (roll < 95) act = ACT_READ;
		else act = 3'($urandom_range(5, 7));
		c = make_cmd(act, pick_gene(), 3'($urandom_range(0, 7)), pick_gene(), pick_gene(),
			{$urandom, $urandom}, 2'($urandom_range(0, 3)));
		return c;
	endfunction

	initial begin
		no_gaps = 1'b0;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gene 0 reads itself after reset: cycle
		send_cmd(make_cmd(ACT_EVAL, 8'd0, FN_NOP, 8'd0, 8'd0, 64'd0, MUT_SRC_A));
		send_cmd(make_cmd(ACT_OVERRIDE, 8'd1, FN_NOP, 8'd0, 8'd0, '1, MUT_SRC_A));
		send_cmd(make_cmd(ACT_OVERRIDE, 8'd2, FN_NOP, 8'd0, 8'd0,
			64'h0123_4567_89AB_CDEF, MUT_SRC_A));
		for (int f = 0; f < 8; f++)
			send_cmd(make_cmd(ACT_LOAD, 8'(10 + f), 3'(f), 8'd1, 8'd2, '1, MUT_SRC_A));
		for (int f = 0; f < 8; f++)
			send_cmd(make_cmd(ACT_EVAL, 8'(10 + f), FN_NOP, 8'd0, 8'd0, 64'd0, MUT_SRC_A));
		send_cmd(make_cmd(ACT_MUTATE, 8'd17, FN_AND, 8'd255, 8'd3, 64'd0, MUT_SRC_A));
		send_cmd(make_cmd(ACT_MUTATE, 8'd16, FN_AND, 8'd9, 8'd9, 64'd0, 2'd3));
		// self loop through source b
		send_cmd(make_cmd(ACT_LOAD, 8'd255, FN_AND, 8'd1, 8'd255, 64'd0, MUT_SRC_A));
		send_cmd(make_cmd(ACT_EVAL, 8'd255, FN_NOP, 8'd0, 8'd0, 64'd0, MUT_SRC_A));
		send_cmd(make_cmd(ACT_READ, 8'd17, FN_NOP, 8'd0, 8'd0, 64'd0, MUT_SRC_A));
		send_cmd(make_cmd(3'd5, 8'd3, FN_XNOR, 8'd4, 8'd5, '1, MUT_FUNC));
		send_cmd(make_cmd(3'd7, 8'd255, FN_XNOR, 8'd255, 8'd255, '1, 2'd3));

		for (int n = 0; n < RANDOM_CMDS; n++) begin
			no_gaps = (n >= 600 && n < 1000);
			if (n == 300 || n == 1400) begin
				start <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
			send_cmd(random_cmd());
		end
		start <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("logic_gene_network_evaluator regression: pass");
		else
			$display("logic_gene_network_evaluator regression: fail");
		$finish;
	end

endmodule
